// ----- hdl/tals_pkg.sv -----
// Shared types and constants of the two-axis line stepper.
package tals_pkg;

  localparam int PosWidth   = 16;
  localparam int CoordWidth = 16;
  localparam int WideWidth  = (PosWidth > CoordWidth) ? PosWidth : CoordWidth;
  localparam int LenWidth   = WideWidth + 1;
  localparam int AccWidth   = WideWidth + 2;
  localparam int DeltaWidth = WideWidth + 1;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int AddrWidth = 3;
  localparam int DataWidth = 32;
  localparam logic [AddrWidth-1:0] AddrAbsoluteMode = 3'd0;

  localparam logic [1:0] FuncMove = 2'd0;
  localparam logic [1:0] FuncTick = 2'd1;
  localparam logic [1:0] FuncSet  = 2'd2;

  typedef logic [PosWidth-1:0]          pos_t;
  typedef logic [LenWidth-1:0]          len_t;
  typedef logic signed [AccWidth-1:0]   acc_t;
  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DeltaWidth-1:0] delta_t;

  typedef enum logic [1:0] {
    OP_MOVE,
    OP_TICK,
    OP_SET,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t    op;
    coord_t coord_x;
    coord_t coord_y;
  } cmd_t;

  typedef struct packed {
    logic   accepted;
    logic   step_x;
    logic   step_y;
    logic   dir_x;
    logic   dir_y;
    logic   busy;
    coord_t position_x;
    coord_t position_y;
  } result_t;

  typedef struct packed {
    logic moving;
    logic steps_zero;
  } back_status_t;

endpackage

// ----- hdl/tals_front.sv -----
// Front end: takes input transactions and classifies them into commands for the queue.
module tals_front (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               func,
  input  tals_pkg::coord_t         coord_x,
  input  tals_pkg::coord_t         coord_y,
  input  logic                     q_full,
  output logic                     push,
  output tals_pkg::cmd_t           push_cmd
);

  tals_pkg::op_t op;

  always_comb begin
    case (func)
      tals_pkg::FuncMove: op = tals_pkg::OP_MOVE;
      tals_pkg::FuncTick: op = tals_pkg::OP_TICK;
      tals_pkg::FuncSet:  op = tals_pkg::OP_SET;
      default:            op = tals_pkg::OP_NONE;
    endcase
  end

  assign in_stall         = q_full;
  assign push             = in_valid && !q_full;
  assign push_cmd.op      = op;
  assign push_cmd.coord_x = coord_x;
  assign push_cmd.coord_y = coord_y;

endmodule

// ----- hdl/tals_queue.sv -----
// Two-entry command queue between the front end and the motion back end.
module tals_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  tals_pkg::cmd_t              push_cmd,
  input  logic                        pop,
  output logic                        q_valid,
  output logic                        q_full,
  output tals_pkg::cmd_t              head,
  output logic [tals_pkg::QCntW-1:0]  count
);

  tals_pkg::cmd_t mem [tals_pkg::QDepth];
  logic [tals_pkg::QPtrW-1:0] wr_ptr;
  logic [tals_pkg::QPtrW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head    = mem[rd_ptr];
  assign q_valid = (count != '0);
  assign q_full  = (count == tals_pkg::QCntW'(tals_pkg::QDepth));

endmodule

// ----- hdl/tals_back.sv -----
// Back end: carries out moves, ticks and position loads and holds the result register.
module tals_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   absolute_mode,
  input  logic                   q_valid,
  input  tals_pkg::cmd_t         head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tals_pkg::result_t      result,
  output tals_pkg::back_status_t status
);

  tals_pkg::pos_t pos_x, pos_x_next;
  tals_pkg::pos_t pos_y, pos_y_next;
  tals_pkg::len_t major_len, major_len_next;
  tals_pkg::len_t minor_len, minor_len_next;
  tals_pkg::len_t steps_left, steps_left_next;
  tals_pkg::acc_t error_acc, error_acc_next;
  logic           minor_pending, minor_pending_next;
  logic           x_is_major, x_is_major_next;
  logic           equal_mode, equal_mode_next;
  logic [1:0]     dir_bits, dir_bits_next;
  logic           moving, moving_next;

  tals_pkg::delta_t cx_ext, cy_ext, dx, dy;
  tals_pkg::len_t   ax, ay;
  tals_pkg::acc_t   acc_sum;
  logic             minor_due;
  logic             stepx, stepy;
  logic             accepted;
  tals_pkg::len_t   steps_dec;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    cx_ext = tals_pkg::DeltaWidth'(head.coord_x);
    cy_ext = tals_pkg::DeltaWidth'(head.coord_y);
    if (absolute_mode) begin
      dx = cx_ext - $signed({pos_x[tals_pkg::PosWidth-1], pos_x});
      dy = cy_ext - $signed({pos_y[tals_pkg::PosWidth-1], pos_y});
    end else begin
      dx = cx_ext;
      dy = cy_ext;
    end
    ax = dx[tals_pkg::DeltaWidth-1] ? tals_pkg::len_t'(-dx) : tals_pkg::len_t'(dx);
    ay = dy[tals_pkg::DeltaWidth-1] ? tals_pkg::len_t'(-dy) : tals_pkg::len_t'(dy);

    // The error term is kept scaled by the major length, so comparing twice
    // the error with the major length is the half-step threshold.
    acc_sum   = error_acc + $signed({1'b0, minor_len});
    minor_due = $signed({acc_sum, 1'b0}) > $signed({2'b00, major_len});
    steps_dec = steps_left - 1'b1;
  end

  always_comb begin
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    major_len_next     = major_len;
    minor_len_next     = minor_len;
    steps_left_next    = steps_left;
    error_acc_next     = error_acc;
    minor_pending_next = minor_pending;
    x_is_major_next    = x_is_major;
    equal_mode_next    = equal_mode;
    dir_bits_next      = dir_bits;
    moving_next        = moving;
    accepted           = 1'b0;
    stepx              = 1'b0;
    stepy              = 1'b0;
    case (head.op)
      tals_pkg::OP_MOVE: begin
        if (!moving) begin
          dir_bits_next      = {!dy[tals_pkg::DeltaWidth-1], !dx[tals_pkg::DeltaWidth-1]};
          equal_mode_next    = (ax == ay);
          x_is_major_next    = (ax > ay);
          major_len_next     = (ax > ay) ? ax : ay;
          minor_len_next     = (ax > ay) ? ay : ax;
          steps_left_next    = (ax > ay) ? ax : ay;
          error_acc_next     = '0;
          minor_pending_next = 1'b0;
          moving_next        = (ax != '0) || (ay != '0);
          accepted           = 1'b1;
        end
      end
      tals_pkg::OP_TICK: begin
        if (moving) begin
          if (equal_mode) begin
            stepx = 1'b1;
            stepy = 1'b1;
          end else begin
            stepx              = x_is_major || minor_pending;
            stepy              = !x_is_major || minor_pending;
            minor_pending_next = minor_due;
            error_acc_next     = minor_due ? acc_sum - $signed({1'b0, major_len}) : acc_sum;
          end
          if (stepx) begin
            pos_x_next = dir_bits[0] ? pos_x + 1'b1 : pos_x - 1'b1;
          end
          if (stepy) begin
            pos_y_next = dir_bits[1] ? pos_y + 1'b1 : pos_y - 1'b1;
          end
          steps_left_next = steps_dec;
          // A minor step still queued on the last major step is dropped.
          if (steps_dec == '0) begin
            moving_next        = 1'b0;
            minor_pending_next = 1'b0;
          end
        end
      end
      tals_pkg::OP_SET: begin
        pos_x_next = tals_pkg::pos_t'(cx_ext);
        pos_y_next = tals_pkg::pos_t'(cy_ext);
        accepted   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      major_len     <= '0;
      minor_len     <= '0;
      steps_left    <= '0;
      error_acc     <= '0;
      minor_pending <= 1'b0;
      x_is_major    <= 1'b0;
      equal_mode    <= 1'b0;
      dir_bits      <= '0;
      moving        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        pos_x         <= pos_x_next;
        pos_y         <= pos_y_next;
        major_len     <= major_len_next;
        minor_len     <= minor_len_next;
        steps_left    <= steps_left_next;
        error_acc     <= error_acc_next;
        minor_pending <= minor_pending_next;
        x_is_major    <= x_is_major_next;
        equal_mode    <= equal_mode_next;
        dir_bits      <= dir_bits_next;
        moving        <= moving_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.accepted   <= accepted;
      result.step_x     <= stepx;
      result.step_y     <= stepy;
      result.dir_x      <= dir_bits_next[0];
      result.dir_y      <= dir_bits_next[1];
      result.busy       <= moving_next;
      result.position_x <= tals_pkg::CoordWidth'(pos_x_next);
      result.position_y <= tals_pkg::CoordWidth'(pos_y_next);
    end
  end

  assign status.moving     = moving;
  assign status.steps_zero = (steps_left == '0);

endmodule

// ----- hdl/two_axis_line_stepper.sv -----
// Top level of the two-axis line stepper: front end, command queue, back end, register port.
//
// Usage: each input transaction carries func (move, tick or set) with coord_x and
// coord_y; each one yields exactly one result transaction with the step pulses,
// direction bits, busy flag and both positions after that item. A transaction
// is taken on a rising edge with in_valid high and in_stall low; results leave
// when out_valid is high and out_stall low.
// An accepted input is written into the two-entry command queue; once the back end
// pops it, its update of the interpolator state (an add, a compare and a
// conditional subtract) ends in the result register, which drives out_valid.
// One item is taken per cycle when the output is not stalled.
// When the receiver stalls, the result register holds, the back end stops
// draining the queue, and in_stall rises once both queue entries are full.
// Reset clears positions and the move state and sets absolute mode. The
// absolute_mode register sits at byte address 0 of the APB port and should be
// written only while no transaction is in flight.
module two_axis_line_stepper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        func,
  input  logic signed [15:0]                coord_x,
  input  logic signed [15:0]                coord_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              accepted,
  output logic                              step_x,
  output logic                              step_y,
  output logic                              dir_x,
  output logic                              dir_y,
  output logic                              busy_res,
  output logic signed [15:0]                position_x,
  output logic signed [15:0]                position_y,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tals_pkg::AddrWidth-1:0]    paddr,
  input  logic [tals_pkg::DataWidth-1:0]    pwdata,
  output logic [tals_pkg::DataWidth-1:0]    prdata,
  output logic                              pready
);

  logic                        absolute_mode;
  logic                        push;
  tals_pkg::cmd_t              push_cmd;
  logic                        pop;
  logic                        q_valid;
  logic                        q_full;
  tals_pkg::cmd_t              head;
  logic [tals_pkg::QCntW-1:0]  q_count;
  tals_pkg::result_t           result;
  tals_pkg::back_status_t      status;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == tals_pkg::AddrAbsoluteMode);

  always_ff @(posedge clk) begin
    if (rst) begin
      absolute_mode <= 1'b1;
    end else if (cfg_write) begin
      absolute_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == tals_pkg::AddrAbsoluteMode) begin
      prdata[0] = absolute_mode;
    end
  end

  tals_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tals_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head),
    .count    (q_count)
  );

  tals_back u_back (
    .clk           (clk),
    .rst           (rst),
    .absolute_mode (absolute_mode),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result        (result),
    .status        (status)
  );

  assign accepted   = result.accepted;
  assign step_x     = result.step_x;
  assign step_y     = result.step_y;
  assign dir_x      = result.dir_x;
  assign dir_y      = result.dir_y;
  assign busy_res   = result.busy;
  assign position_x = result.position_x;
  assign position_y = result.position_y;

  // An accepted transaction always leaves something in the queue.
  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (q_count != '0))
    else $error("queue empty after an accepted input transaction");

  // Step pulses come only from tick items, which never report acceptance.
  a_step_not_accepted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (step_x || step_y)) |-> !accepted)
    else $error("step result flagged as accepted");

  // A move in progress always has major steps left to issue.
  a_moving_has_steps: assert property (@(posedge clk) disable iff (rst)
    status.moving |-> !status.steps_zero)
    else $error("move in progress with no steps left");

endmodule
